/* hw/rtl/nrpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node range pattern parser package
// Shared character codes, result kinds and the event handed from the parser
// to the result stage.
// ----------------------------------------------------------------------------
package nrpp_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOWER_O = 8'h6F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // result kinds on the output stream
    localparam logic [1:0] RK_FORMAT = 2'd0;
    localparam logic [1:0] RK_OK     = 2'd1;
    localparam logic [1:0] RK_BAD    = 2'd2;

    localparam int COUNT_W = 34;
    localparam int OUT_IDX_W = 32;
    localparam int DCOUNT_W = 7;
    localparam logic [DCOUNT_W-1:0] DCOUNT_MAX = 7'd99;

    typedef enum logic [1:0] {
        EV_CHAR,
        EV_FMT,
        EV_OK,
        EV_BAD
    } evt_kind_t;

    typedef struct packed {
        evt_kind_t                  kind;
        logic [7:0]                 ch;
        logic [OUT_IDX_W-1:0]       start_idx;
        logic [OUT_IDX_W-1:0]       end_idx;
        logic [COUNT_W-1:0]         count;
        logic [DCOUNT_W-1:0]        dcount;
        logic                       octal;
    } evt_t;

endpackage

/* hw/rtl/nrpp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node range pattern parser - character parser
// Holds the parse state and, while the result stage is ready, turns one
// character per cycle into at most one event for the result stage.
// ----------------------------------------------------------------------------
module nrpp_parser #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ch_valid,
    input  logic            ch_ready,
    input  logic [7:0]      ch,
    output logic            evt_valid,
    output nrpp_pkg::evt_t  evt
);
    import nrpp_pkg::*;

    localparam int W  = INDEX_WIDTH;
    localparam int SW = (INDEX_WIDTH > OUT_IDX_W) ? INDEX_WIDTH : OUT_IDX_W;
    localparam int CW = (INDEX_WIDTH > COUNT_W) ? INDEX_WIDTH : COUNT_W;

    localparam logic [2:0] PH_TEXT   = 3'd0;
    localparam logic [2:0] PH_ESCAPE = 3'd1;
    localparam logic [2:0] PH_OPEN   = 3'd2;
    localparam logic [2:0] PH_START  = 3'd3;
    localparam logic [2:0] PH_END    = 3'd4;
    localparam logic [2:0] PH_DROP   = 3'd5;

    logic [2:0]          phase_reg, phase_next;
    logic                seen_reg, seen_next;
    logic                octal_reg, octal_next;
    logic [W-1:0]        start_reg, start_next;
    logic [W-1:0]        end_reg, end_next;
    logic [DCOUNT_W-1:0] dcount_reg, dcount_next;

    logic                is_digit;
    logic                acc_octal;
    logic [W-1:0]        acc_in;
    logic [W-1:0]        acc_out;
    logic [SW-1:0]       start_ext;
    logic [SW-1:0]       end_ext;
    logic [CW-1:0]       diff;
    logic                evt_has;

    function automatic logic [W-1:0] acc_step(input logic [W-1:0] v, input logic oct,
                                               input logic [3:0] d);
        logic [W-1:0] x8;
        logic [W-1:0] x2;
        x8 = v << 3;
        x2 = oct ? '0 : (v << 1);
        return x8 + x2 + {{(W-4){1'b0}}, d};
    endfunction

    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    // the first start digit right after '[' always counts in decimal
    assign acc_octal = (phase_reg == PH_OPEN) ? 1'b0 : octal_reg;
    assign acc_in    = (phase_reg == PH_END) ? end_reg : start_reg;
    assign acc_out   = acc_step(acc_in, acc_octal, ch[3:0]);
    assign start_ext = SW'(start_reg);
    assign end_ext   = SW'(end_reg);
    assign diff      = CW'(end_reg) - CW'(start_reg) + CW'(1);

    always_comb begin
        phase_next  = phase_reg;
        seen_next   = seen_reg;
        octal_next  = octal_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        dcount_next = dcount_reg;
        evt_has     = 1'b0;
        evt         = '0;
        evt.ch      = ch;
        evt.dcount  = dcount_reg;
        evt.octal   = octal_reg;

        // start part handling shared by the open and start phases
        if ((phase_reg == PH_START) ||
            (phase_reg == PH_OPEN && ch != CH_NUL && !seen_reg && ch != CH_LOWER_O)) begin
            if (is_digit) begin
                start_next = acc_out;
                if (dcount_reg < DCOUNT_MAX) begin
                    dcount_next = dcount_reg + 1'b1;
                end
            end else if (ch == CH_DASH) begin
                phase_next = PH_END;
            end else begin
                evt_has = 1'b1;
                evt.kind = EV_BAD;
            end
        end

        unique case (phase_reg)
            PH_TEXT: begin
                if (ch == CH_NUL) begin
                    evt_has = 1'b1;
                    evt.kind = EV_OK;
                end else if (ch == CH_BSLASH) begin
                    phase_next = PH_ESCAPE;
                end else if (ch == CH_LBRACK) begin
                    phase_next = PH_OPEN;
                end else begin
                    evt_has = 1'b1;
                    evt.kind = EV_CHAR;
                end
            end
            PH_ESCAPE: begin
                evt_has = 1'b1;
                if (ch == CH_NUL) begin
                    evt.kind = EV_OK;
                end else begin
                    evt.kind = EV_CHAR;
                    phase_next = PH_TEXT;
                end
            end
            PH_OPEN: begin
                if (ch == CH_NUL) begin
                    evt_has = 1'b1;
                    evt.kind = EV_OK;
                end else if (seen_reg) begin
                    evt_has = 1'b1;
                    evt.kind = EV_BAD;
                end else if (ch == CH_LOWER_O) begin
                    octal_next = 1'b1;
                    phase_next = PH_START;
                end else begin
                    octal_next = 1'b0;
                    if (ch != CH_DASH) begin
                        phase_next = PH_START;
                    end
                end
            end
            PH_START: begin
            end
            PH_END: begin
                if (is_digit) begin
                    end_next = acc_out;
                end else if (ch == CH_RBRACK) begin
                    evt_has = 1'b1;
                    evt.kind = EV_FMT;
                    seen_next = 1'b1;
                    phase_next = PH_TEXT;
                end else begin
                    evt_has = 1'b1;
                    evt.kind = EV_BAD;
                end
            end
            default: begin
                // drop everything up to the terminating zero byte
                if (ch == CH_NUL) begin
                    phase_next = PH_TEXT;
                end
            end
        endcase

        if (evt_has && evt.kind == EV_OK) begin
            evt.start_idx = start_ext[OUT_IDX_W-1:0];
            evt.end_idx   = end_ext[OUT_IDX_W-1:0];
            evt.count     = seen_reg ? diff[COUNT_W-1:0] : '0;
        end

        if (evt_has && (evt.kind == EV_OK || evt.kind == EV_BAD)) begin
            phase_next  = (evt.kind == EV_BAD && ch != CH_NUL) ? PH_DROP : PH_TEXT;
            seen_next   = 1'b0;
            octal_next  = 1'b0;
            start_next  = '0;
            end_next    = '0;
            dcount_next = '0;
        end
    end

    assign evt_valid = ch_valid && evt_has;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TEXT;
            seen_reg   <= 1'b0;
            octal_reg  <= 1'b0;
            start_reg  <= '0;
            end_reg    <= '0;
            dcount_reg <= '0;
        end else if (ch_valid && ch_ready) begin
            phase_reg  <= phase_next;
            seen_reg   <= seen_next;
            octal_reg  <= octal_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
            dcount_reg <= dcount_next;
        end
    end

endmodule

/* hw/rtl/nrpp_emitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node range pattern parser - result stage
// Registers one event and plays it out as one or more result requests; a
// range event expands into its print format run.
// ----------------------------------------------------------------------------
module nrpp_emitter (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             evt_valid,
    input  nrpp_pkg::evt_t   evt,
    output logic             evt_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [111:0]     m_tdata,  // format_char, start_index, end_index,
                                       // index_count, zero pad
    output logic [1:0]       m_tuser,  // result_kind
    output logic             m_tlast
);
    import nrpp_pkg::*;

    logic        full_reg;
    evt_t        evt_reg;
    logic [2:0]  step_reg;

    logic        has_tens;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [6:0]  tens_x10;
    logic        last_step;
    logic        take;
    logic [1:0]  kind;
    logic [7:0]  fchar;
    logic [7:0]  suffix;

    // divide the digit count by ten with a reciprocal multiply (exact for any 7-bit count)
    assign tens_prod = {8'd0, evt_reg.dcount} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign tens_x10  = {3'd0, tens} * 7'd10;
    assign ones      = 4'(evt_reg.dcount - tens_x10);
    assign has_tens  = evt_reg.dcount > 7'd9;
    assign suffix    = evt_reg.octal ? CH_LOWER_O : CH_LOWER_D;

    assign last_step = (evt_reg.kind != EV_FMT) ||
                       (step_reg == (has_tens ? 3'd4 : 3'd3));
    assign take      = full_reg && m_tready;
    assign evt_ready = !full_reg || (take && last_step);

    always_comb begin
        fchar = 8'd0;
        case (evt_reg.kind)
            EV_CHAR: fchar = evt_reg.ch;
            EV_FMT: begin
                case (step_reg)
                    3'd0: fchar = CH_PCT;
                    3'd1: fchar = CH_DOT;
                    3'd2: fchar = has_tens ? (CH_ZERO + {4'd0, tens})
                                           : (CH_ZERO + {4'd0, ones});
                    3'd3: fchar = has_tens ? (CH_ZERO + {4'd0, ones}) : suffix;
                    default: fchar = suffix;
                endcase
            end
            default: fchar = 8'd0;
        endcase
    end

    always_comb begin
        unique case (evt_reg.kind)
            EV_OK:   kind = RK_OK;
            EV_BAD:  kind = RK_BAD;
            default: kind = RK_FORMAT;
        endcase
    end

    assign m_tvalid = full_reg;
    assign m_tlast  = (evt_reg.kind == EV_OK) || (evt_reg.kind == EV_BAD);
    assign m_tuser  = kind;
    assign m_tdata  = {6'd0, evt_reg.count, evt_reg.end_idx, evt_reg.start_idx, fchar};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            step_reg <= '0;
        end else if (evt_valid && evt_ready) begin
            full_reg <= 1'b1;
            step_reg <= '0;
        end else if (take) begin
            if (last_step) begin
                full_reg <= 1'b0;
            end else begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_valid && evt_ready) begin
            evt_reg <= evt;
        end
    end

endmodule

/* hw/rtl/node_range_pattern_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node range pattern parser core
// Streams a host-name pattern such as node[003-234] and returns its print
// format characters followed by a finish request with start, end and count.
// ----------------------------------------------------------------------------
// One pattern character is taken per cycle while the result stage is ready;
// its result request is registered. Every character yields at most one result
// request, except the closing bracket of a range, which yields a run of four
// or five format characters ('%', '.', digit count, 'd' or 'o'); the result
// register plays that run out one request per cycle while m_tready is high and
// stalls the input until the run ends. A new character is taken in the same
// cycle that the last pending result is consumed. Range values are kept at
// INDEX_WIDTH bits and wrap; reported start and end are their low 32 bits.
module node_range_pattern_parser_core #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // ch
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // format_char[7:0], start_index[39:8],
                                    // end_index[71:40], index_count[105:72],
                                    // zero pad
    output logic [1:0]   m_tuser,   // result_kind[1:0]
    output logic         m_tlast    // last
);
    import nrpp_pkg::*;

    logic evt_valid;
    evt_t evt;
    logic evt_ready;

    nrpp_parser #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ch_valid  (s_tvalid),
        .ch_ready  (evt_ready),
        .ch        (s_tdata),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    nrpp_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_valid (evt_valid),
        .evt       (evt),
        .evt_ready (evt_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign s_tready = evt_ready;

endmodule

/* tb/sv/node_range_pattern_parser_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node range pattern parser core testbench
// Streams host-name patterns into the parser, one character per request, and
// checks every format and finish result against a behavioral parser kept
// here. A short table of hand-picked characters comes first, then random
// patterns, mostly well-formed ranges with random content, plus truncated
// patterns and raw byte noise. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module node_range_pattern_parser_core_tb;
    import nrpp_pkg::*;

    localparam int RAND_ITEMS  = 440;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN       = 16;
    localparam int DIR_N       = 27;

    typedef enum logic [2:0] {
        PS_TEXT,
        PS_ESC,
        PS_OPEN,
        PS_START,
        PS_END,
        PS_DROP
    } text_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  fchar;
        logic [31:0] start_idx;
        logic [31:0] end_idx;
        logic [33:0] count;
        logic        last;
    } fmt_result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        logic [1:0] kind;
        logic [7:0] fchar;
        logic       last;
    } dir_row_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        fmt_result_t want;
        logic        pause_before;
        logic        hold_before;
    } char_req_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    node_range_pattern_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // hand-picked characters; expected result typed in where it is obvious
    dir_row_t dir_tab [0:DIR_N-1] = '{
        '{"n",       1'b1, RK_FORMAT, "n",     1'b0},
        '{8'hFF,     1'b1, RK_FORMAT, 8'hFF,   1'b0},
        '{CH_BSLASH, 1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_LBRACK, 1'b1, RK_FORMAT, CH_LBRACK, 1'b0},
        '{CH_NUL,    1'b1, RK_OK,     CH_NUL,  1'b1},
        '{CH_LBRACK, 1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_LOWER_O, 1'b0, RK_FORMAT, CH_NUL, 1'b0},
        '{"7",       1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_DASH,   1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_NINE,   1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_RBRACK, 1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_LBRACK, 1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{"x",       1'b1, RK_BAD,    CH_NUL,  1'b1},
        '{"q",       1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_NUL,    1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_BSLASH, 1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_NUL,    1'b1, RK_OK,     CH_NUL,  1'b1},
        '{CH_LBRACK, 1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_NUL,    1'b1, RK_OK,     CH_NUL,  1'b1},
        '{CH_LBRACK, 1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{"1",       1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{"a",       1'b1, RK_BAD,    CH_NUL,  1'b1},
        '{CH_NUL,    1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_LBRACK, 1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{"5",       1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_DASH,   1'b0, RK_FORMAT, CH_NUL,  1'b0},
        '{CH_NUL,    1'b1, RK_BAD,    CH_NUL,  1'b1}
    };

    char_req_t   char_q [$];
    logic [7:0]  pat_q [$];
    fmt_result_t pred_q [$];
    fmt_result_t pending_q [$];

    // parser state mirrored here
    text_phase_t             phase;
    logic                    range_seen;
    logic                    octal;
    logic [31:0]             range_lo;
    logic [31:0]             range_hi;
    logic [DCOUNT_W-1:0]     dig_count;

    int  taken_idx;
    int  errors;
    int  shown;
    int  results_seen;
    int  ranges_closed;
    int  bad_finishes;
    int  stall_cycles;
    bit  hold_req;

    task automatic clear_parse();
        phase      = PS_TEXT;
        range_seen = 1'b0;
        octal      = 1'b0;
        range_lo   = '0;
        range_hi   = '0;
        dig_count  = '0;
    endtask

    task automatic emit_fmt(input logic [7:0] c);
        pred_q.push_back('{RK_FORMAT, c, 32'd0, 32'd0, 34'd0, 1'b0});
    endtask

    task automatic finish_ok();
        logic [33:0] n;
        n = range_seen ? ({2'b00, range_hi} - {2'b00, range_lo} + 34'd1) : 34'd0;
        pred_q.push_back('{RK_OK, 8'd0, range_lo, range_hi, n, 1'b1});
        clear_parse();
    endtask

    task automatic finish_bad(input logic [7:0] c);
        pred_q.push_back('{RK_BAD, 8'd0, 32'd0, 32'd0, 34'd0, 1'b1});
        bad_finishes++;
        clear_parse();
        if (c != CH_NUL)
            phase = PS_DROP;
    endtask

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [31:0] accumulate(input logic [31:0] v, input logic [7:0] c);
        logic [31:0] base;
        base = octal ? 32'd8 : 32'd10;
        return v * base + {24'd0, c - CH_ZERO};
    endfunction

    task automatic start_digit(input logic [7:0] c);
        if (is_digit(c)) begin
            range_lo = accumulate(range_lo, c);
            if (dig_count < DCOUNT_MAX)
                dig_count++;
        end else if (c == CH_DASH) begin
            phase = PS_END;
        end else begin
            finish_bad(c);
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        case (phase)
            PS_TEXT: begin
                if (c == CH_NUL)
                    finish_ok();
                else if (c == CH_BSLASH)
                    phase = PS_ESC;
                else if (c == CH_LBRACK)
                    phase = PS_OPEN;
                else
                    emit_fmt(c);
            end
            PS_ESC: begin
                if (c == CH_NUL) begin
                    finish_ok();
                end else begin
                    emit_fmt(c);
                    phase = PS_TEXT;
                end
            end
            PS_OPEN: begin
                if (c == CH_NUL) begin
                    finish_ok();
                end else if (range_seen) begin
                    finish_bad(c);
                end else if (c == CH_LOWER_O) begin
                    octal = 1'b1;
                    phase = PS_START;
                end else begin
                    octal = 1'b0;
                    phase = PS_START;
                    start_digit(c);
                end
            end
            PS_START: start_digit(c);
            PS_END: begin
                if (is_digit(c)) begin
                    range_hi = accumulate(range_hi, c);
                end else if (c == CH_RBRACK) begin
                    emit_fmt(CH_PCT);
                    emit_fmt(CH_DOT);
                    if (dig_count > 7'd9)
                        emit_fmt(CH_ZERO + {1'b0, dig_count / 7'd10});
                    emit_fmt(CH_ZERO + {1'b0, dig_count % 7'd10});
                    emit_fmt(octal ? CH_LOWER_O : CH_LOWER_D);
                    range_seen = 1'b1;
                    phase = PS_TEXT;
                    ranges_closed++;
                end else begin
                    finish_bad(c);
                end
            end
            default: begin
                if (c == CH_NUL)
                    clear_parse();
            end
        endcase
    endtask

    task automatic gen_digits(input int n);
        for (int k = 0; k < n; k++)
            pat_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    function automatic int draw_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
    endfunction

    // one text character, escaped now and then
    task automatic gen_plain();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) begin
            pat_q.push_back(CH_BSLASH);
            pat_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            c = 8'($urandom_range(1, 255));
            while (c == CH_BSLASH || c == CH_LBRACK)
                c = 8'($urandom_range(1, 255));
            pat_q.push_back(c);
        end
    endtask

    task automatic gen_wellformed();
        int n;
        pat_q.delete();
        n = $urandom_range(0, 4);
        repeat (n) gen_plain();
        if ($urandom_range(0, 5) != 0) begin
            pat_q.push_back(CH_LBRACK);
            if ($urandom_range(0, 1) != 0)
                pat_q.push_back(CH_LOWER_O);
            gen_digits(draw_len());
            pat_q.push_back(CH_DASH);
            gen_digits(draw_len());
            pat_q.push_back(CH_RBRACK);
            n = $urandom_range(0, 3);
            repeat (n) gen_plain();
            // a second range opener ends the pattern
            if ($urandom_range(0, 4) == 0) begin
                pat_q.push_back(CH_LBRACK);
                if ($urandom_range(0, 1) != 0)
                    pat_q.push_back(8'($urandom_range(1, 255)));
            end
        end
        pat_q.push_back(CH_NUL);
    endtask

    // scoreboard: predict on each accepted request, then check each result
    always @(posedge aclk) begin : scoreboard
        fmt_result_t got;
        fmt_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred_q.delete();
                parse_char(s_tdata);
                if (taken_idx < char_q.size() && char_q[taken_idx].typed) begin
                    pending_q.push_back(char_q[taken_idx].want);
                end else begin
                    foreach (pred_q[k])
                        pending_q.push_back(pred_q[k]);
                end
                taken_idx++;
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tuser[1:0], m_tdata[7:0], m_tdata[39:8], m_tdata[71:40],
                        m_tdata[105:72], m_tlast};
                results_seen++;
                if (pending_q.size() == 0) begin
                    errors++;
                    if (shown < 10)
                        $display("ERROR: unexpected result kind %0d char %02h last %0d",
                                 got.kind, got.fchar, got.last);
                    shown++;
                end else begin
                    want = pending_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (shown < 10) begin
                            $display("ERROR: result %0d mismatch", results_seen);
                            $display("  expected kind %0d char %02h start %08h end %08h count %09h last %0d",
                                     want.kind, want.fchar, want.start_idx, want.end_idx,
                                     want.count, want.last);
                            $display("  actual   kind %0d char %02h start %08h end %08h count %09h last %0d",
                                     got.kind, got.fchar, got.start_idx, got.end_idx,
                                     got.count, got.last);
                        end
                        shown++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ERROR: no progress for %0d cycles, %0d results pending",
                         stall_cycles, pending_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin : result_sink
        int gap;
        int cnt;
        bit calm;
        m_tready <= 1'b0;
        cnt  = 0;
        calm = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (cnt % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            cnt++;
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
        end
    end

    initial begin : stimulus
        char_req_t req;
        int        gap;
        int        npat;
        bit        calm;
        bit        mid_paused;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        aresetn  <= 1'b0;
        clear_parse();
        taken_idx     = 0;
        errors        = 0;
        shown         = 0;
        results_seen  = 0;
        ranges_closed = 0;
        bad_finishes  = 0;
        hold_req      = 1'b0;

        foreach (dir_tab[r]) begin
            req = '0;
            req.ch    = dir_tab[r].ch;
            req.typed = dir_tab[r].typed;
            req.want  = '{dir_tab[r].kind, dir_tab[r].fchar, 32'd0, 32'd0, 34'd0,
                          dir_tab[r].last};
            char_q.push_back(req);
        end

        npat       = 0;
        mid_paused = 1'b0;
        while (char_q.size() < DIR_N + RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                7: begin
                    // truncated pattern, maybe with a stray byte before the end
                    gen_wellformed();
                    gap = $urandom_range(0, pat_q.size() - 1);
                    while (pat_q.size() > gap)
                        void'(pat_q.pop_back());
                    if ($urandom_range(0, 1) != 0)
                        pat_q.push_back(8'($urandom_range(0, 255)));
                    pat_q.push_back(CH_NUL);
                end
                8, 9: begin
                    pat_q.delete();
                    gap = $urandom_range(1, 8);
                    repeat (gap) pat_q.push_back(8'($urandom_range(0, 255)));
                    pat_q.push_back(CH_NUL);
                end
                default: gen_wellformed();
            endcase
            // once: a start part long enough to saturate the digit count
            if (npat == 5) begin
                pat_q.delete();
                pat_q.push_back(CH_LBRACK);
                gen_digits(104);
                pat_q.push_back(CH_DASH);
                gen_digits(1);
                pat_q.push_back(CH_RBRACK);
                pat_q.push_back(CH_NUL);
            end
            foreach (pat_q[k]) begin
                req = '0;
                req.ch = pat_q[k];
                if (k == 0) begin
                    req.pause_before = (npat == 0) ||
                        (!mid_paused && char_q.size() > DIR_N + RAND_ITEMS / 2);
                    req.hold_before = (npat == 2);
                    if (req.pause_before && npat != 0)
                        mid_paused = 1'b1;
                end
                char_q.push_back(req);
            end
            npat++;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        calm = 1'b0;
        foreach (char_q[i]) begin
            if (char_q[i].pause_before) begin
                // hold until every pending result is out
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_q.size() != 0)
                    @(posedge aclk);
            end
            if (char_q[i].hold_before)
                hold_req = 1'b1;
            if (i % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= char_q[i].ch;
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
        end
        s_tvalid <= 1'b0;

        // let the scoreboard book the last request before draining
        @(posedge aclk);
        while (pending_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("Summary: %0d characters in %0d random patterns, %0d results checked",
                 taken_idx, npat, results_seen);
        $display("Summary: %0d ranges closed, %0d invalid finishes, %0d mismatches",
                 ranges_closed, bad_finishes, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
